// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; a user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/hbt_pkg.sv
// Package for the hypercube broadcast tree peer lister.
// Types, microcode table and Gray-code helper; no dependencies.
package hbt_pkg;

    localparam int MAX_ORDER = 8;
    localparam int RANK_W    = 8;
    localparam int CNT_W     = 9;
    localparam int ORDER_CAP = (MAX_ORDER > RANK_W) ? RANK_W : MAX_ORDER;
    localparam int ORDER_W   = $clog2(ORDER_CAP + 1);
    localparam int KIDX_W    = $clog2(RANK_W);

    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << ORDER_CAP;
    localparam logic [CNT_W-1:0] COUNT_RST   = CNT_W'(8);

    typedef enum logic [1:0] {
        KIND_PARENT = 2'd0,
        KIND_CHILD  = 2'd1,
        KIND_ROOT   = 2'd2,
        KIND_RANGE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STEP_WAIT  = 2'd0,
        STEP_PREP  = 2'd1,
        STEP_HEAD  = 2'd2,
        STEP_CHILD = 2'd3
    } step_t;

    typedef enum logic [1:0] {
        COND_ALWAYS     = 2'd0,
        COND_IN_VALID   = 2'd1,
        COND_HEAD_LAST  = 2'd2,
        COND_CHILD_LAST = 2'd3
    } cond_t;

    typedef struct packed {
        logic  accept;
        logic  prep;
        logic  emit_head;
        logic  emit_child;
        cond_t cond;
        step_t jmp_true;
        step_t jmp_false;
    } uword_t;

    typedef struct packed {
        logic load_q;
        logic prep;
        logic emit_head;
        logic emit_child;
    } ctrl_t;

    typedef struct packed {
        logic head_last;
        logic child_last;
    } stat_t;

    typedef struct packed {
        kind_t             kind;
        logic [RANK_W-1:0] rank;
        logic              last;
    } res_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = '{accept: 1'b0, prep: 1'b0, emit_head: 1'b0, emit_child: 1'b0,
              cond: COND_ALWAYS, jmp_true: STEP_WAIT, jmp_false: STEP_WAIT};
        case (s)
            STEP_WAIT:
            begin
                w.accept    = 1'b1;
                w.cond      = COND_IN_VALID;
                w.jmp_true  = STEP_PREP;
                w.jmp_false = STEP_WAIT;
            end
            STEP_PREP:
            begin
                w.prep      = 1'b1;
                w.cond      = COND_ALWAYS;
                w.jmp_true  = STEP_HEAD;
                w.jmp_false = STEP_HEAD;
            end
            STEP_HEAD:
            begin
                w.emit_head = 1'b1;
                w.cond      = COND_HEAD_LAST;
                w.jmp_true  = STEP_WAIT;
                w.jmp_false = STEP_CHILD;
            end
            STEP_CHILD:
            begin
                w.emit_child = 1'b1;
                w.cond       = COND_CHILD_LAST;
                w.jmp_true   = STEP_WAIT;
                w.jmp_false  = STEP_CHILD;
            end
            default:
            begin
                w.cond = COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

    function automatic logic [RANK_W-1:0] gray_dec(input logic [RANK_W-1:0] g);
        logic [RANK_W-1:0] r;
        r[RANK_W-1] = g[RANK_W-1];
        for (int i = RANK_W - 2; i >= 0; i--)
        begin
            r[i] = r[i+1] ^ g[i];
        end
        return r;
    endfunction

endpackage

// File: sv/hbt_seq.sv
// Microcode sequencer: step counter, control ROM lookup, conditional jumps.
// Depends on hbt_pkg.
module hbt_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          slot_free,
    input  hbt_pkg::stat_t stat,
    output logic          in_ready,
    output hbt_pkg::ctrl_t ctrl
);
    import hbt_pkg::*;

    step_t  step_reg, step_next;
    uword_t w;
    logic   cond_ok;
    logic   emit_wait;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_WAIT;
        else
            step_reg <= step_next;
    end

    always_comb
    begin
        w = ucode(step_reg);
        case (w.cond)
            COND_ALWAYS:     cond_ok = 1'b1;
            COND_IN_VALID:   cond_ok = in_valid;
            COND_HEAD_LAST:  cond_ok = stat.head_last;
            COND_CHILD_LAST: cond_ok = stat.child_last;
            default:         cond_ok = 1'b1;
        endcase
        emit_wait = (w.emit_head | w.emit_child) & ~slot_free;
        if (emit_wait)
            step_next = step_reg;
        else if (cond_ok)
            step_next = w.jmp_true;
        else
            step_next = w.jmp_false;

        in_ready        = w.accept;
        ctrl.load_q     = w.accept & in_valid;
        ctrl.prep       = w.prep;
        ctrl.emit_head  = w.emit_head & slot_free;
        ctrl.emit_child = w.emit_child & slot_free;
    end

endmodule

// File: sv/hbt_datapath.sv
// Datapath: Gray code, parent, cube order and child mask; one result per emit.
// Depends on hbt_pkg.
module hbt_datapath (
    input  logic                       clk,
    input  logic [hbt_pkg::CNT_W-1:0]  node_count,
    input  logic [hbt_pkg::RANK_W-1:0] query_rank,
    input  hbt_pkg::ctrl_t             ctrl,
    output hbt_pkg::stat_t             stat,
    output hbt_pkg::res_t              res
);
    import hbt_pkg::*;

    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] g_reg, g_next;
    logic              oor_reg, oor_next;
    logic              root_reg, root_next;
    logic [RANK_W-1:0] par_reg, par_next;
    logic [RANK_W-1:0] mask_reg, mask_next;

    logic [CNT_W-1:0]   count;
    logic [ORDER_W-1:0] order;
    logic [ORDER_W-1:0] low;
    logic [RANK_W-1:0]  cand;
    logic [KIDX_W-1:0]  kidx;
    logic [RANK_W-1:0]  mask_left;
    logic [RANK_W-1:0]  child;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_q)
            rank_reg <= query_rank;
        if (ctrl.prep)
        begin
            g_reg    <= g_next;
            oor_reg  <= oor_next;
            root_reg <= root_next;
            par_reg  <= par_next;
        end
        if (ctrl.prep || ctrl.emit_child)
            mask_reg <= mask_next;
    end

    // setup for one query
    always_comb
    begin
        count     = (node_count > COUNT_LIMIT) ? COUNT_LIMIT : node_count;
        oor_next  = {1'b0, rank_reg} >= count;
        g_next    = rank_reg ^ (rank_reg >> 1);
        root_next = (g_next == '0);
        par_next  = gray_dec(g_next & (g_next - RANK_W'(1)));

        order = ORDER_W'(ORDER_CAP);
        for (int o = ORDER_CAP - 1; o >= 0; o--)
        begin
            if ((CNT_W'(1) << o) >= count)
                order = ORDER_W'(o);
        end

        low = order;
        for (int k = RANK_W - 1; k >= 0; k--)
        begin
            if (g_next[k])
                low = ORDER_W'(k);
        end

        for (int k = 0; k < RANK_W; k++)
        begin
            cand = gray_dec(g_next | (RANK_W'(1) << k));
            mask_next[k] = (ORDER_W'(k) < low) && ({1'b0, cand} < count) && !oor_next;
        end

        // highest pending child
        kidx = '0;
        for (int k = 0; k < RANK_W; k++)
        begin
            if (mask_reg[k])
                kidx = KIDX_W'(k);
        end
        mask_left = mask_reg & ~(RANK_W'(1) << kidx);
        child     = gray_dec(g_reg | (RANK_W'(1) << kidx));
        if (ctrl.emit_child)
            mask_next = mask_left;

        stat.head_last  = oor_reg | (mask_reg == '0);
        stat.child_last = (mask_left == '0);

        if (ctrl.emit_child)
            res = '{kind: KIND_CHILD, rank: child, last: stat.child_last};
        else if (oor_reg)
            res = '{kind: KIND_RANGE, rank: '0, last: 1'b1};
        else if (root_reg)
            res = '{kind: KIND_ROOT, rank: '0, last: stat.head_last};
        else
            res = '{kind: KIND_PARENT, rank: par_reg, last: stat.head_last};
    end

endmodule

// File: sv/hypercube_broadcast_tree_peers_core.sv
// Hypercube binomial broadcast tree peer lister, top level.
// The accept step registers the query, the setup step the Gray code, parent and mask, and each
// emit step one result, waiting while the output is stalled; one result per cycle otherwise.
// A query with n results (1 to 9) takes the accept step, one setup step and n emit steps.
// Reset: node_count = 8, sequencer at its wait step, output register empty.
module hypercube_broadcast_tree_peers_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [hbt_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hbt_pkg::RANK_W-1:0] query_rank,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 peer_kind,
    output logic [hbt_pkg::RANK_W-1:0] peer_rank,
    output logic                       last
);
    import hbt_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg;
    logic             slot_free;
    ctrl_t            ctrl;
    stat_t            stat;
    res_t             res;

    assign slot_free = ~out_valid_reg | out_ready;

    hbt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .slot_free (slot_free),
        .stat      (stat),
        .in_ready  (in_ready),
        .ctrl      (ctrl)
    );

    hbt_datapath u_dp (
        .clk        (clk),
        .node_count (count_reg),
        .query_rank (query_rank),
        .ctrl       (ctrl),
        .stat       (stat),
        .res        (res)
    );

    always_comb
    begin
        if (ctrl.emit_head || ctrl.emit_child)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_head || ctrl.emit_child)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign peer_kind = out_reg.kind;
    assign peer_rank = out_reg.rank;
    assign last      = out_reg.last;

endmodule

// File: sv/hbt_checker.sv
// Port-level checker for the peer lister, bound to the top level.
// Depends on hbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hbt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 peer_kind,
    input logic [hbt_pkg::RANK_W-1:0] peer_rank,
    input logic                       last
);
    import hbt_pkg::*;

    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(peer_kind) && $stable(peer_rank) && $stable(last), "output changed while stalled")
    `ASSERT_NEVER(a_range_single, out_valid && peer_kind == KIND_RANGE && (!last || peer_rank != '0), "range error must be a lone zero-rank result")
    `ASSERT_NEVER(a_root_rank, out_valid && peer_kind == KIND_ROOT && peer_rank != '0, "root marker with nonzero rank")
    `ASSERT_NEVER(a_no_overlap, out_valid && !last && in_ready, "new query taken before the current one finished")

endmodule

bind hypercube_broadcast_tree_peers_core hbt_checker u_chk (.*);
